// ===== rtl/mdalu_pkg.sv =====
// Shared constants for the multiply/divide unit: stream field layout,
// operand widths and sequencer state codes.
// No dependencies.
package mdalu_pkg;

    localparam int unsigned OpWidth   = 16;
    localparam int unsigned WideWidth = 32;
    localparam int unsigned InDataW   = 64;
    localparam int unsigned InUserW   = 2;
    localparam int unsigned OutDataW  = 48;
    localparam int unsigned CountW    = 5;

    // Bit positions inside s_axis_tuser.
    localparam int unsigned UserActionBit = 0;
    localparam int unsigned UserSignedBit = 1;

    // Operation codes carried in the action bit.
    localparam logic ActMultiply = 1'b0;
    localparam logic ActDivide   = 1'b1;

    // Step counts, loaded as the count minus one.
    localparam logic [CountW-1:0] MulLastStep = CountW'(OpWidth - 1);
    localparam logic [CountW-1:0] DivLastStep = CountW'(WideWidth - 1);

    // Sequencer states.
    localparam logic [1:0] StIdle   = 2'd0;
    localparam logic [1:0] StRun    = 2'd1;
    localparam logic [1:0] StFinish = 2'd2;

endpackage

// ===== rtl/mul_div_alu_16x16_32by16.sv =====
// Top level of the 16x16 multiply and 32-by-16 divide unit.
// Depends on mdalu_pkg for field layout, step counts and state codes.
//
// This unit takes one transaction at a time on the slave stream and returns
// one result transaction on the master stream. Every operation runs on a single
// shared 18-bit add/subtract unit that a small sequencer steps: a multiply is
// 16 shift-and-add steps, a divide is 32 restoring shift-and-subtract steps.
// Each operation goes through an accept step, its iterations and a final
// sign-correction step; a divide by zero skips the iterations and goes
// straight to the final step. The slave side is ready only while the
// sequencer is idle. Results sit in an output register, so the unit can accept
// the next transaction while the previous result still waits on the master
// side; only the final write of a new result waits for that register to drain.
// Signed mode works on magnitudes and fixes the signs at the end, so results
// truncate toward zero and the remainder takes the dividend's sign. A divide
// by zero returns quotient zero and the low 16 bits of the dividend as the
// remainder, and the signed minimum divided by minus one returns 0x80000000
// with remainder zero. The remainder register is written by every divide,
// kept across multiplies, reported with every result and cleared by reset.
module mul_div_alu_16x16_32by16
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // wide_operand[31:0], multiplicand[47:32], divisor_value[63:48]
    input  logic [mdalu_pkg::InDataW-1:0]  s_axis_tdata,
    // action[0], signed_mode[1]
    input  logic [mdalu_pkg::InUserW-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // main_result[31:0], remainder_out[47:32]
    output logic [mdalu_pkg::OutDataW-1:0] m_axis_tdata
);

    localparam int unsigned OpW   = mdalu_pkg::OpWidth;
    localparam int unsigned WideW = mdalu_pkg::WideWidth;

    // Unpacked input fields.
    logic             in_action;
    logic             in_signed;
    logic [WideW-1:0] in_wide;
    logic [OpW-1:0]   in_mcand;
    logic [OpW-1:0]   in_divisor;

    assign in_action  = s_axis_tuser[mdalu_pkg::UserActionBit];
    assign in_signed  = s_axis_tuser[mdalu_pkg::UserSignedBit];
    assign in_wide    = s_axis_tdata[WideW-1:0];
    assign in_mcand   = s_axis_tdata[WideW+OpW-1:WideW];
    assign in_divisor = s_axis_tdata[WideW+2*OpW-1:WideW+OpW];

    // Sequencer and datapath registers. The hi/lo pair is the shifting
    // accumulator: hi holds the partial remainder or the upper product half,
    // lo holds the quotient bits or the multiplier and lower product half.
    logic [1:0]                   state_reg,   state_next;
    logic [mdalu_pkg::CountW-1:0] count_reg,   count_next;
    logic [OpW:0]                 hi_reg,      hi_next;
    logic [WideW-1:0]             lo_reg,      lo_next;
    logic [OpW-1:0]               m_reg,       m_next;
    logic                         is_div_reg,  is_div_next;
    logic                         neg_q_reg,   neg_q_next;
    logic                         neg_r_reg,   neg_r_next;
    logic [OpW-1:0]               rem_reg,     rem_next;
    logic                         ovalid_reg,  ovalid_next;
    logic [WideW-1:0]             oresult_reg, oresult_next;
    logic [OpW-1:0]               orem_reg,    orem_next;

    logic accept;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == mdalu_pkg::StIdle);

    // Operand magnitudes for signed mode.
    logic             neg_a, neg_b, neg_d, neg_v;
    logic [OpW-1:0]   mag_a, mag_b, mag_v;
    logic [WideW-1:0] mag_d;

    always_comb
    begin
        neg_a = in_signed && in_mcand[OpW-1];
        neg_b = in_signed && in_wide[OpW-1];
        neg_d = in_signed && in_wide[WideW-1];
        neg_v = in_signed && in_divisor[OpW-1];
        mag_a = neg_a ? (~in_mcand + 1'b1) : in_mcand;
        mag_b = neg_b ? (~in_wide[OpW-1:0] + 1'b1) : in_wide[OpW-1:0];
        mag_d = neg_d ? (~in_wide + 1'b1) : in_wide;
        mag_v = neg_v ? (~in_divisor + 1'b1) : in_divisor;
    end

    // Shared add/subtract unit. Multiply adds the multiplicand to the upper
    // product half; divide subtracts the divisor from the shifted remainder,
    // and the top bit of the 18-bit result is the borrow.
    logic [OpW:0]   alu_a;
    logic [OpW+1:0] alu_sum;

    always_comb
    begin
        if (is_div_reg)
        begin
            alu_a   = {hi_reg[OpW-1:0], lo_reg[WideW-1]};
            alu_sum = {1'b0, alu_a} - {2'b00, m_reg};
        end
        else
        begin
            alu_a   = {1'b0, hi_reg[OpW-1:0]};
            alu_sum = {1'b0, alu_a} + {2'b00, m_reg};
        end
    end

    // Sign correction of the finished magnitudes.
    logic [WideW-1:0] mag_main;
    logic [WideW-1:0] fin_main;
    logic [OpW-1:0]   fin_rem;
    logic             out_free;

    always_comb
    begin
        mag_main = is_div_reg ? lo_reg : {hi_reg[OpW-1:0], lo_reg[OpW-1:0]};
        fin_main = neg_q_reg ? (~mag_main + 1'b1) : mag_main;
        fin_rem  = neg_r_reg ? (~hi_reg[OpW-1:0] + 1'b1) : hi_reg[OpW-1:0];
        out_free = !ovalid_reg || m_axis_tready;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        m_next       = m_reg;
        is_div_next  = is_div_reg;
        neg_q_next   = neg_q_reg;
        neg_r_next   = neg_r_reg;
        rem_next     = rem_reg;
        ovalid_next  = ovalid_reg && !m_axis_tready;
        oresult_next = oresult_reg;
        orem_next    = orem_reg;

        case (state_reg)
            mdalu_pkg::StIdle:
            begin
                if (accept)
                begin
                    is_div_next = (in_action == mdalu_pkg::ActDivide);
                    hi_next     = '0;
                    if (in_action == mdalu_pkg::ActDivide)
                    begin
                        if (in_divisor == '0)
                        begin
                            // Divide by zero: no iterations, raw low dividend
                            // bits become the remainder.
                            lo_next    = '0;
                            hi_next    = {1'b0, in_wide[OpW-1:0]};
                            neg_q_next = 1'b0;
                            neg_r_next = 1'b0;
                            state_next = mdalu_pkg::StFinish;
                        end
                        else
                        begin
                            lo_next    = mag_d;
                            m_next     = mag_v;
                            neg_q_next = neg_d ^ neg_v;
                            neg_r_next = neg_d;
                            count_next = mdalu_pkg::DivLastStep;
                            state_next = mdalu_pkg::StRun;
                        end
                    end
                    else
                    begin
                        lo_next    = {{(WideW-OpW){1'b0}}, mag_b};
                        m_next     = mag_a;
                        neg_q_next = neg_a ^ neg_b;
                        neg_r_next = 1'b0;
                        count_next = mdalu_pkg::MulLastStep;
                        state_next = mdalu_pkg::StRun;
                    end
                end
            end

            mdalu_pkg::StRun:
            begin
                if (is_div_reg)
                begin
                    if (!alu_sum[OpW+1])
                    begin
                        hi_next = alu_sum[OpW:0];
                        lo_next = {lo_reg[WideW-2:0], 1'b1};
                    end
                    else
                    begin
                        hi_next = alu_a;
                        lo_next = {lo_reg[WideW-2:0], 1'b0};
                    end
                end
                else
                begin
                    if (lo_reg[0])
                    begin
                        hi_next = {1'b0, alu_sum[OpW:1]};
                        lo_next = {lo_reg[WideW-1:OpW], alu_sum[0], lo_reg[OpW-1:1]};
                    end
                    else
                    begin
                        hi_next = {1'b0, hi_reg[OpW:1]};
                        lo_next = {lo_reg[WideW-1:OpW], hi_reg[0], lo_reg[OpW-1:1]};
                    end
                end
                count_next = count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    state_next = mdalu_pkg::StFinish;
                end
            end

            mdalu_pkg::StFinish:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    oresult_next = fin_main;
                    if (is_div_reg)
                    begin
                        rem_next  = fin_rem;
                        orem_next = fin_rem;
                    end
                    else
                    begin
                        orem_next = rem_reg;
                    end
                    state_next = mdalu_pkg::StIdle;
                end
            end

            default:
            begin
                state_next = mdalu_pkg::StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mdalu_pkg::StIdle;
            count_reg  <= '0;
            rem_reg    <= '0;
            ovalid_reg <= 1'b0;
            is_div_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rem_reg    <= rem_next;
            ovalid_reg <= ovalid_next;
            is_div_reg <= is_div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        m_reg       <= m_next;
        neg_q_reg   <= neg_q_next;
        neg_r_reg   <= neg_r_next;
        oresult_reg <= oresult_next;
        orem_reg    <= orem_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {orem_reg, oresult_reg};

    // A divide by zero goes straight to the finishing step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_action == mdalu_pkg::ActDivide && in_divisor == '0)
        |=> (state_reg == mdalu_pkg::StFinish))
    else $error("divide by zero did not bypass the iterations");

    // A multiply never runs more than its 16 steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mdalu_pkg::StRun && !is_div_reg)
        |-> (count_reg <= mdalu_pkg::MulLastStep))
    else $error("multiply step count out of range");

    // The remainder register is left alone by a multiply.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mdalu_pkg::StFinish && !is_div_reg) |=> $stable(rem_reg))
    else $error("multiply changed the remainder register");

    // An accepted transaction leaves the slave side closed in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
    else $error("slave side stayed ready after a transaction");

endmodule
